// File: hw/rtl/pbfs_pkg.sv
// ----------------------------------------------------------------------------
// pbfs_pkg
// Shared types and constants of the packed bit field store: field widths,
// stream packing, default geometry, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pbfs_pkg;

    // item field widths
    localparam int POS_W = 15;
    localparam int CNT_W = 6;
    localparam int VAL_W = 32;
    localparam int RD_W  = 32;

    // largest bit position an item can carry
    localparam int POS_MAX = (1 << POS_W) - 1;

    // extra fraction bits of the reciprocal used for position / word width
    localparam int DIV_GUARD = 7;

    // stream packing
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int POS_LSB   = 0;
    localparam int CNT_LSB   = POS_LSB + POS_W;
    localparam int VAL_LSB   = CNT_LSB + CNT_W;

    // default geometry
    localparam int PBFS_WORD_BITS   = 32;
    localparam int PBFS_STORE_WORDS = 1024;

    // operation codes carried in tuser
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MOD1,
        ST_MOD2,
        ST_RD0,
        ST_RD1,
        ST_FIN,
        ST_WR1
    } pbfs_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic do_div;
        logic do_mod1;
        logic do_mod2;
        logic calc_next;
        logic mem_rd;
        logic sel_next;
        logic cap_word0;
        logic wr0;
        logic wr1;
        logic load_out;
    } pbfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic straddle;
        logic empty;
    } pbfs_status_t;

endpackage

// File: hw/rtl/packed_bit_field_store_top.sv
// ----------------------------------------------------------------------------
// packed_bit_field_store_top
// Packed bit array in a word memory, read and written by bit fields.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one operation per transfer. tuser selects read or
//   write; tdata carries the bit position, the bit count (saturated to the
//   word width) and the write value. A field may straddle two words; word
//   addresses wrap modulo the depth.
//   Each read produces one transfer on the master stream holding the field,
//   zero-extended. Writes produce no transfer and change only the field bits.
//   One operation is processed at a time; a new one is accepted only once
//   the last has returned to idle. The item passes the reciprocal divide and
//   modulo stages of the address path, then the single memory port reads
//   both words; the result is loaded or the first word written, and the
//   second word of a straddling write after it, as the port writes them in
//   turn. The address arithmetic and the single port set this pace.
//   A result waits in an output register while the receiver stalls; the next
//   operation is still accepted and runs up to its own result, then holds.
//   Reset clears the controller and the result flag only; memory contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module packed_bit_field_store_top
#(
    parameter int WORD_BITS   = pbfs_pkg::PBFS_WORD_BITS,
    parameter int STORE_WORDS = pbfs_pkg::PBFS_STORE_WORDS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // bit_position [14:0], bit_count [20:15], write_value [52:21], zero pad
    input  logic [pbfs_pkg::S_TDATA_W-1:0]   s_tdata,
    // func [0]
    input  logic [pbfs_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data [31:0]
    output logic [pbfs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pbfs_pkg::*;

    pbfs_cmd_t    cmd;
    pbfs_status_t status;

    // sequencer
    pbfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath and memory
    pbfs_dp
    #(
        .WORD_BITS   (WORD_BITS),
        .STORE_WORDS (STORE_WORDS)
    )
    u_dp
    (
        .clk      (clk),
        .cmd      (cmd),
        .status   (status),
        .in_func  (s_tuser[0]),
        .in_pos   (s_tdata[POS_LSB +: POS_W]),
        .in_cnt   (s_tdata[CNT_LSB +: CNT_W]),
        .in_value (s_tdata[VAL_LSB +: VAL_W]),
        .out_data (m_tdata)
    );

endmodule

// File: hw/rtl/pbfs_ctrl.sv
// ----------------------------------------------------------------------------
// pbfs_ctrl
// Sequencer of the packed bit field store: steps each item through address
// arithmetic, memory reads and read-modify-write, and owns both handshakes.
// ----------------------------------------------------------------------------
module pbfs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  pbfs_pkg::pbfs_status_t status,
    output pbfs_pkg::pbfs_cmd_t    cmd
);
    import pbfs_pkg::*;

    pbfs_state_t state_reg;
    pbfs_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // result slot can take a new value this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = ST_MOD1;
            ST_MOD1: state_next = ST_MOD2;
            ST_MOD2: state_next = ST_RD0;
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (!status.is_write)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.straddle && !status.empty)
                begin
                    state_next = ST_WR1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR1:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // commands and input ready
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_DIV:  cmd.do_div  = 1'b1;
            ST_MOD1: cmd.do_mod1 = 1'b1;
            ST_MOD2: cmd.do_mod2 = 1'b1;
            ST_RD0:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.calc_next = 1'b1;
            end
            ST_RD1:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.sel_next  = 1'b1;
                cmd.cap_word0 = 1'b1;
            end
            ST_FIN:
            begin
                cmd.load_out = !status.is_write && out_free;
                cmd.wr0      = status.is_write && !status.empty;
            end
            ST_WR1:
            begin
                cmd.sel_next = 1'b1;
                cmd.wr1      = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/pbfs_dp.sv
// ----------------------------------------------------------------------------
// pbfs_dp
// Datapath of the packed bit field store: word address and offset by
// reciprocal multiplication, the word memory, field extract and merge, and
// the result register.
// ----------------------------------------------------------------------------
module pbfs_dp
#(
    parameter int WORD_BITS   = pbfs_pkg::PBFS_WORD_BITS,
    parameter int STORE_WORDS = pbfs_pkg::PBFS_STORE_WORDS
)
(
    input  logic                         clk,
    input  pbfs_pkg::pbfs_cmd_t          cmd,
    output pbfs_pkg::pbfs_status_t       status,
    input  logic                         in_func,
    input  logic [pbfs_pkg::POS_W-1:0]   in_pos,
    input  logic [pbfs_pkg::CNT_W-1:0]   in_cnt,
    input  logic [pbfs_pkg::VAL_W-1:0]   in_value,
    output logic [pbfs_pkg::RD_W-1:0]    out_data
);
    import pbfs_pkg::*;

    // geometry
    localparam int DW  = 2 * WORD_BITS;
    localparam int OW  = $clog2(WORD_BITS);
    localparam int LW  = $clog2(WORD_BITS + 1);
    localparam int AW  = $clog2(STORE_WORDS);
    localparam int QW  = $clog2(POS_MAX / WORD_BITS + 1);

    // position / word width by reciprocal
    localparam int DIV_SHIFT = POS_W + DIV_GUARD;
    localparam int RW        = (1 << DIV_SHIFT) / WORD_BITS;
    localparam int PRW       = POS_W + $clog2(RW + 1);

    // word index modulo depth by reciprocal
    localparam int MT  = QW + 1;
    localparam int RS  = (1 << MT) / STORE_WORDS;
    localparam int M1W = QW + $clog2(RS + 2);
    localparam int M2W = QW + $clog2(STORE_WORDS + 1);

    // captured item
    logic             func_reg;
    logic [POS_W-1:0] pos_reg;
    logic [LW-1:0]    len_reg;
    logic [LW-1:0]    len_next;
    logic [VAL_W-1:0] value_reg;
    logic [PRW-1:0]   prod1_reg;
    logic [PRW-1:0]   prod1_next;

    // address arithmetic
    logic [QW-1:0]    q_est;
    logic [POS_W-1:0] qw_prod;
    logic [POS_W-1:0] rem;
    logic             div_fix;
    logic [QW-1:0]    q_reg;
    logic [QW-1:0]    q_next;
    logic [OW-1:0]    off_reg;
    logic [OW-1:0]    off_next;
    logic [M1W-1:0]   prod2_reg;
    logic [M1W-1:0]   prod2_next;
    logic [LW-1:0]    span;
    logic             straddle_reg;
    logic             straddle_next;
    logic [QW-1:0]    qa;
    logic [M2W-1:0]   qs;
    logic [M2W-1:0]   rem2;
    logic             mod_fix;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    addr_next;
    logic [AW:0]      nxt_inc;
    logic [AW-1:0]    nxt_reg;
    logic [AW-1:0]    nxt_next;

    // memory
    logic [WORD_BITS-1:0] bit_store_mem [STORE_WORDS];
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_BITS-1:0] word0_reg;

    // field extract and merge
    logic [DW-1:0]        combine;
    logic [DW-1:0]        len_mask;
    logic [DW-1:0]        field_mask;
    logic [DW-1:0]        rd_field;
    logic [DW+RD_W-1:0]   rd_wide;
    logic [DW+VAL_W-1:0]  val_wide;
    logic [DW-1:0]        val_ext;
    logic [DW-1:0]        merged;
    logic [WORD_BITS-1:0] wr1_reg;
    logic [RD_W-1:0]      out_reg;
    logic [RD_W-1:0]      out_next;

    // count saturation and first reciprocal product at accept
    assign len_next   = ({1'b0, in_cnt} > 7'(WORD_BITS)) ? LW'(WORD_BITS) : LW'(in_cnt);
    assign prod1_next = PRW'(in_pos) * PRW'(RW);

    // quotient estimate is exact or one low, fix with one compare
    assign q_est    = QW'(prod1_reg >> DIV_SHIFT);
    assign qw_prod  = POS_W'(POS_W'(q_est) * POS_W'(WORD_BITS));
    assign rem      = pos_reg - qw_prod;
    assign div_fix  = rem >= POS_W'(WORD_BITS);
    assign q_next   = div_fix ? q_est + QW'(1) : q_est;
    assign off_next = div_fix ? OW'(rem - POS_W'(WORD_BITS)) : OW'(rem);

    // modulo product and straddle test
    assign prod2_next    = M1W'(q_reg) * M1W'(RS);
    assign span          = LW'(WORD_BITS) - LW'(off_reg);
    assign straddle_next = len_reg > span;

    // word address wraps modulo depth
    assign qa        = QW'(prod2_reg >> MT);
    assign qs        = M2W'(M2W'(qa) * M2W'(STORE_WORDS));
    assign rem2      = M2W'(q_reg) - qs;
    assign mod_fix   = rem2 >= M2W'(STORE_WORDS);
    assign addr_next = mod_fix ? AW'(rem2 - M2W'(STORE_WORDS)) : AW'(rem2);

    // following word with wrap
    assign nxt_inc  = (AW + 1)'(addr_reg) + (AW + 1)'(1);
    assign nxt_next = (nxt_inc == (AW + 1)'(STORE_WORDS)) ? '0 : AW'(nxt_inc);

    // two adjacent words as one window
    assign combine    = {rdata_reg, word0_reg};
    assign len_mask   = ~({DW{1'b1}} << len_reg);
    assign field_mask = len_mask << off_reg;
    assign rd_field   = (combine >> off_reg) & len_mask;
    assign rd_wide    = {{RD_W{1'b0}}, rd_field};
    assign out_next   = rd_wide[RD_W-1:0];
    assign val_wide   = {{DW{1'b0}}, value_reg};
    assign val_ext    = val_wide[DW-1:0];
    assign merged     = (combine & ~field_mask) | ((val_ext << off_reg) & field_mask);

    // memory port select
    assign mem_addr  = cmd.sel_next ? nxt_reg : addr_reg;
    assign mem_wdata = cmd.wr0 ? merged[WORD_BITS-1:0] : wr1_reg;

    // single port word memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr0 || cmd.wr1)
        begin
            bit_store_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= bit_store_mem[mem_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= in_func;
            pos_reg   <= in_pos;
            len_reg   <= len_next;
            value_reg <= in_value;
            prod1_reg <= prod1_next;
        end
        if (cmd.do_div)
        begin
            q_reg   <= q_next;
            off_reg <= off_next;
        end
        if (cmd.do_mod1)
        begin
            prod2_reg    <= prod2_next;
            straddle_reg <= straddle_next;
        end
        if (cmd.do_mod2)
        begin
            addr_reg <= addr_next;
        end
        if (cmd.calc_next)
        begin
            nxt_reg <= nxt_next;
        end
        if (cmd.cap_word0)
        begin
            word0_reg <= rdata_reg;
        end
        if (cmd.wr0)
        begin
            wr1_reg <= merged[DW-1:WORD_BITS];
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    // status and result
    assign status.is_write = (func_reg == FUNC_WRITE);
    assign status.straddle = straddle_reg;
    assign status.empty    = (len_reg == '0);
    assign out_data        = out_reg;

endmodule
